// ===== src/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, codes and default sizes for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  // default geometry and number format
  localparam int MM_MAX_DIM   = 8;
  localparam int MM_FRAC_BITS = 16;
  localparam int MM_WORD_W    = 32;

  // request commands
  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  localparam logic [3:0] SIZE_RESET = 4'd4;

  // row and column tags along the cell chain, wide enough for every size
  typedef logic [3:0] mm_tag_t;

  // request payload
  typedef struct packed {
    logic [1:0]                  cmd;
    logic [2:0]                  row_index;
    logic [2:0]                  col_index;
    logic signed [MM_WORD_W-1:0] elem_value;
  } mm_in_t;

  // result payload
  typedef struct packed {
    logic [2:0]                  out_row;
    logic [2:0]                  out_col;
    logic signed [MM_WORD_W-1:0] out_value;
    logic                        last;
  } mm_out_t;

  // element of A travelling from cell to cell
  typedef struct packed {
    logic                        vld;
    logic                        first;
    logic                        last;
    mm_tag_t                     tag;
    mm_tag_t                     row;
    logic signed [MM_WORD_W-1:0] val;
  } mm_flow_t;

  // write of one B element, broadcast to every cell
  typedef struct packed {
    logic                 we;
    mm_tag_t              row;
    mm_tag_t              col;
    logic [MM_WORD_W-1:0] val;
  } mm_bload_t;

  // finished dot product of one cell
  typedef struct packed {
    logic                        vld;
    mm_tag_t                     row;
    logic signed [MM_WORD_W-1:0] val;
  } mm_res_t;

endpackage

// ===== src/mm_ram.sv =====
// ----------------------------------------------------------------------------
// mm_ram
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mm_ram
  import mm_pkg::*;
#(
  parameter int WIDTH = MM_WORD_W,
  parameter int DEPTH = MM_MAX_DIM * MM_MAX_DIM,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mm_cell.sv =====
// ----------------------------------------------------------------------------
// mm_cell
// One column of the result: holds a column of B, multiplies the passing A
// element by it, accumulates the dot product and hands A on to its neighbour.
// ----------------------------------------------------------------------------
module mm_cell
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MM_MAX_DIM,
  parameter int FRAC_BITS = MM_FRAC_BITS,
  parameter int CELL_ID   = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mm_flow_t  flow_in,
  input  mm_bload_t bload,
  output mm_flow_t  flow_out,
  output mm_res_t   res
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SH_W  = 2 * MM_WORD_W - FRAC_BITS;
  localparam int ACC_W = SH_W + IDX_W + 1;

  // local column of B with its written flags
  logic [MM_WORD_W-1:0] b_mem_r [MAX_DIM];
  logic [MAX_DIM-1:0]   b_ok_r;

  mm_flow_t x_r;

  logic signed [MM_WORD_W-1:0]   b_sel;
  logic signed [2*MM_WORD_W-1:0] prod_nxt;
  logic signed [2*MM_WORD_W-1:0] prod_r;
  logic                          p_vld_r;
  logic                          p_first_r;
  logic                          p_last_r;
  mm_tag_t                       p_row_r;

  logic signed [SH_W-1:0]  sh;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-32:0]       acc_hi;
  logic [MM_WORD_W-1:0]    sat_val;

  logic                 res_vld_r;
  mm_tag_t              res_row_r;
  logic [MM_WORD_W-1:0] res_val_r;

  // multiply stage, an unwritten B element reads as zero
  always_comb begin
    b_sel    = b_ok_r[x_r.tag[IDX_W-1:0]] ? $signed(b_mem_r[x_r.tag[IDX_W-1:0]]) : '0;
    prod_nxt = x_r.val * b_sel;
  end

  // floor shift back to Q16.16 and accumulate
  always_comb begin
    sh       = $signed(prod_r[2*MM_WORD_W-1:FRAC_BITS]);
    acc_base = p_first_r ? '0 : acc_r;
    acc_nxt  = acc_base + ACC_W'(sh);
  end

  // saturate the sum to 32 bits
  always_comb begin
    acc_hi = acc_nxt[ACC_W-1:31];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_val = acc_nxt[31:0];
    end else if (acc_nxt[ACC_W-1]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      p_vld_r   <= 1'b0;
      res_vld_r <= 1'b0;
      b_ok_r    <= '0;
    end else begin
      x_r       <= flow_in;
      p_vld_r   <= x_r.vld;
      res_vld_r <= p_vld_r && p_last_r;
      if (bload.we && (bload.col == 4'(CELL_ID))) begin
        b_ok_r[bload.row[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (bload.we && (bload.col == 4'(CELL_ID))) begin
      b_mem_r[bload.row[IDX_W-1:0]] <= bload.val;
    end
    prod_r    <= prod_nxt;
    p_first_r <= x_r.first;
    p_last_r  <= x_r.last;
    p_row_r   <= x_r.row;
    if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (p_vld_r && p_last_r) begin
      res_row_r <= p_row_r;
      res_val_r <= sat_val;
    end
  end

  assign flow_out = x_r;
  assign res      = '{vld: res_vld_r, row: res_row_r, val: res_val_r};

endmodule

// ===== src/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point C = A x B on a chain of column cells
// Load requests never raise busy. A compute request gives one row of cols_b
// results at a time, rows_a rows in all. Busy stays high through the run and
// while the chain drains; results cannot be stalled.
// Synchronous reset zeroes the stores through written flags, sizes to 4.
// ----------------------------------------------------------------------------
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MM_MAX_DIM,
  parameter int FRAC_BITS = MM_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  mm_in_t     in_req,
  output logic       out_strobe,
  output mm_out_t    out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SZ_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [3:0] rows_a_r;
  logic [3:0] inner_size_r;
  logic [3:0] cols_b_r;

  logic [SZ_W-1:0] m_sz;
  logic [SZ_W-1:0] k_sz;
  logic [SZ_W-1:0] n_sz;
  logic [SZ_W-1:0] period;

  logic accept;
  logic [7:0]       ld_row8;
  logic [7:0]       ld_col8;
  logic [IDX_W-1:0] ld_row;
  logic [IDX_W-1:0] ld_col;
  logic             a_in_range;
  logic             b_in_range;
  logic             a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [ADDR_W-1:0] a_raddr;
  logic [DEPTH-1:0]  a_ok_r;
  logic [MM_WORD_W-1:0] a_rdata;

  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] t_r;
  logic [SZ_W-1:0]  t_ext;
  logic [SZ_W-1:0]  row_ext;
  logic             issue;
  logic             t_wrap;
  logic             row_last;

  logic             iss_vld_r;
  logic             iss_first_r;
  logic             iss_last_r;
  logic [IDX_W-1:0] iss_tag_r;
  logic [IDX_W-1:0] iss_row_r;
  logic             a_ok_rd_r;

  mm_bload_t bload;
  mm_flow_t  flow_w [MAX_DIM+1];
  mm_res_t   res_w  [MAX_DIM];

  logic [MAX_DIM-1:0] sel_vec;
  logic               sel_strobe;
  mm_out_t            sel_data;
  logic               out_strobe_r;
  mm_out_t            out_data_r;

  // size register to working size, zero acts as one, large values clip
  function automatic logic [SZ_W-1:0] eff_size(input logic [3:0] v);
    logic [4:0] vx;
    vx = {1'b0, v};
    if (v == 4'd0) begin
      return SZ_W'(1);
    end else if (vx > 5'(MAX_DIM)) begin
      return SZ_W'(MAX_DIM);
    end
    return SZ_W'(v);
  endfunction

  assign m_sz   = eff_size(rows_a_r);
  assign k_sz   = eff_size(inner_size_r);
  assign n_sz   = eff_size(cols_b_r);
  assign period = (k_sz > n_sz) ? k_sz : n_sz;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // load request decode and range checks
  always_comb begin
    ld_row8    = 8'(in_req.row_index);
    ld_col8    = 8'(in_req.col_index);
    ld_row     = ld_row8[IDX_W-1:0];
    ld_col     = ld_col8[IDX_W-1:0];
    a_in_range = (ld_row8 < 8'(m_sz)) && (ld_col8 < 8'(k_sz));
    b_in_range = (ld_row8 < 8'(k_sz)) && (ld_col8 < 8'(n_sz));
    a_we       = accept && (in_req.cmd == CMD_LOAD_A) && a_in_range;
    a_waddr    = ADDR_W'(ld_row) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col);
    bload      = '{we:  accept && (in_req.cmd == CMD_LOAD_B) && b_in_range,
                   row: 4'(in_req.row_index),
                   col: 4'(in_req.col_index),
                   val: in_req.elem_value};
  end

  // row and inner-step sequencing
  always_comb begin
    t_ext    = SZ_W'(t_r);
    row_ext  = SZ_W'(row_r);
    issue    = (state_r == ST_RUN) && (t_ext < k_sz);
    t_wrap   = (t_ext == period - SZ_W'(1));
    row_last = (row_ext == m_sz - SZ_W'(1));
    a_raddr  = ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(t_r);
  end

  mm_ram #(
    .WIDTH (MM_WORD_W),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_req.elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // control state, size registers and written flags of A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rows_a_r     <= SIZE_RESET;
      inner_size_r <= SIZE_RESET;
      cols_b_r     <= SIZE_RESET;
      a_ok_r       <= '0;
      row_r        <= '0;
      t_r          <= '0;
      iss_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_A:     rows_a_r     <= cfg_wdata;
          REG_INNER_SIZE: inner_size_r <= cfg_wdata;
          REG_COLS_B:     cols_b_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (a_we) begin
        a_ok_r[a_waddr] <= 1'b1;
      end
      iss_vld_r    <= issue;
      out_strobe_r <= sel_strobe;

      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_req.cmd == CMD_COMPUTE)) begin
            state_r <= ST_RUN;
            row_r   <= '0;
            t_r     <= '0;
          end
        end
        ST_RUN: begin
          if (t_wrap) begin
            t_r   <= '0;
            row_r <= row_r + IDX_W'(1);
            if (row_last) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            t_r <= t_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // run ends once the final row has left the last cell of the chain
          if (res_w[MAX_DIM-1].vld &&
              (res_w[MAX_DIM-1].row == 4'(m_sz - SZ_W'(1)))) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // tags of the A element being read
  always_ff @(posedge clk) begin
    iss_first_r <= (t_r == '0);
    iss_last_r  <= (t_ext == k_sz - SZ_W'(1));
    iss_tag_r   <= t_r;
    iss_row_r   <= row_r;
    a_ok_rd_r   <= a_ok_r[a_raddr];
    out_data_r  <= sel_data;
  end

  // head of the chain, an unwritten A element reads as zero
  assign flow_w[0] = '{vld:   iss_vld_r,
                       first: iss_first_r,
                       last:  iss_last_r,
                       tag:   4'(iss_tag_r),
                       row:   4'(iss_row_r),
                       val:   a_ok_rd_r ? a_rdata : '0};

  // one cell per result column
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mm_cell #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS),
      .CELL_ID   (j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .flow_in  (flow_w[j]),
      .bload    (bload),
      .flow_out (flow_w[j+1]),
      .res      (res_w[j])
    );
  end

  // pick the cell that has just finished, columns past cols_b are dropped
  always_comb begin
    sel_vec  = '0;
    sel_data = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (res_w[j].vld && (SZ_W'(j) < n_sz)) begin
        sel_vec[j]         = 1'b1;
        sel_data.out_row   = 3'(res_w[j].row);
        sel_data.out_col   = 3'(j);
        sel_data.out_value = res_w[j].val;
        sel_data.last      = (8'(res_w[j].row) == 8'(m_sz - SZ_W'(1))) &&
                             (SZ_W'(j) == n_sz - SZ_W'(1));
      end
    end
    sel_strobe = |sel_vec;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTH
  // results only come out of a compute run
  a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r != ST_IDLE))
    else $error("result strobe outside a compute run");

  // row spacing keeps the finishing cells apart
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("two cells finished in the same cycle");

  // a compute request always starts a run
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.cmd == CMD_COMPUTE)) |=> busy)
    else $error("compute request did not raise busy");

  // A elements leave the chain in inner-step order, without gaps within a row
  a_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (flow_w[MAX_DIM].vld && !flow_w[MAX_DIM].first) |->
      ($past(flow_w[MAX_DIM].vld) && (flow_w[MAX_DIM].tag == $past(flow_w[MAX_DIM].tag) + 4'd1)))
    else $error("A elements out of order along the chain");
`endif

endmodule
